// ----- rtl/core/wsro_pkg.sv -----
// shared types, constants and the odometer increment table for the wheel speed block
package wsro_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PULSE  = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W  = 1;
    localparam logic [0:0] CFG_DIAM_MAX = 1'd0;
    localparam logic [0:0] CFG_DIAM_MIN = 1'd1;

    localparam logic [7:0] DIAM_MAX_RESET = 8'd200;
    localparam logic [7:0] DIAM_MIN_RESET = 8'd1;
    localparam logic [7:0] DIAM_RESET     = 8'd65;

    localparam logic [2:0] PULSES_PER_MEASURE = 3'd5;

    // measurement arithmetic
    localparam int          DIV_NUM_W     = 19;
    localparam int          DIV_DEN_W     = 16;
    localparam int          DIV_CNT_W     = $clog2(DIV_NUM_W + 1);
    localparam logic [18:0] RPM_NUMERATOR = 19'd300000;
    localparam logic [9:0]  SPEED_FACTOR  = 10'd565;
    localparam logic [15:0] THROTTLE_DIV  = 16'd1022;

    // time base periods
    localparam logic [2:0] FAST_LAST = 3'd4;
    localparam logic [8:0] SLOW_LAST = 9'd499;

    // odometer: 16.32 fixed point km, increment = round(d * pi * 2^32 / 1e5 km), pi taken as 3.14161
    localparam int          ACCUM_W    = 48;
    localparam int          ODO_INC_W  = 26;
    localparam logic [63:0] PI_X100000 = 64'd314161;
    localparam logic [63:0] ODO_DENOM  = 64'd10000000000;
    localparam logic [63:0] ODO_HALF   = 64'd5000000000;

    typedef logic [ODO_INC_W-1:0] odo_inc_table_t [256];

    function automatic odo_inc_table_t build_odo_inc_table();
        odo_inc_table_t tbl;
        logic [63:0]    prod;
        for (int d = 0; d < 256; d++)
        begin
            prod   = (64'(d) * PI_X100000) << 32;
            tbl[d] = ODO_INC_W'((prod + ODO_HALF) / ODO_DENOM);
        end
        return tbl;
    endfunction

    localparam odo_inc_table_t ODO_INC_TABLE = build_odo_inc_table();

    typedef struct packed {
        logic [1:0] kind;
        logic       plus_pressed;
        logic       minus_pressed;
        logic [9:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [15:0] rpm;
        logic [15:0] speed_kmh;
        logic [7:0]  throttle_duty;
        logic [7:0]  diameter_cm;
        logic [15:0] odometer_km;
        logic        fast_strobe;
        logic        slow_strobe;
        logic        measure_done;
    } out_item_t;

    typedef struct packed {
        logic fast;
        logic slow;
    } tick_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/core/wsro_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module wsro_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [wsro_pkg::DIV_NUM_W-1:0] num,
    input  logic [wsro_pkg::DIV_DEN_W-1:0] den,
    output logic [wsro_pkg::DIV_NUM_W-1:0] quot,
    output wsro_pkg::div_status_t          status
);
    import wsro_pkg::*;

    logic [DIV_NUM_W-1:0] work_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 q_bit;
    logic [DIV_DEN_W-1:0] rem_next;

    // shift in the next dividend bit, subtract when it fits
    // a zero divisor always fits, so the quotient comes out all ones
    always_comb
    begin
        trial    = {rem_reg, work_reg[DIV_NUM_W-1]};
        q_bit    = (trial >= {1'b0, den_reg});
        rem_next = q_bit ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            work_reg <= {work_reg[DIV_NUM_W-2:0], q_bit};
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quot        = work_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

// ----- rtl/core/wsro_timebase.sv -----
// millisecond counter with 5 ms and 500 ms phase counters
module wsro_timebase (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    output logic [31:0]            time_ms,
    output wsro_pkg::tick_status_t strobes
);
    import wsro_pkg::*;

    logic [31:0] time_reg;
    logic [2:0]  fast_cnt_reg;
    logic [8:0]  slow_cnt_reg;

    logic        wrap;
    logic [2:0]  fast_cnt_next;
    logic [8:0]  slow_cnt_next;

    // at the 32-bit wrap the time lands on zero, a multiple of both periods
    always_comb
    begin
        wrap = (time_reg == '1);
        if (wrap || fast_cnt_reg == FAST_LAST)
            fast_cnt_next = '0;
        else
            fast_cnt_next = fast_cnt_reg + 1'b1;
        if (wrap || slow_cnt_reg == SLOW_LAST)
            slow_cnt_next = '0;
        else
            slow_cnt_next = slow_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            fast_cnt_reg <= '0;
            slow_cnt_reg <= '0;
        end
        else if (advance)
        begin
            time_reg     <= time_reg + 1'b1;
            fast_cnt_reg <= fast_cnt_next;
            slow_cnt_reg <= slow_cnt_next;
        end
    end

    assign time_ms      = time_reg;
    assign strobes.fast = (fast_cnt_next == '0);
    assign strobes.slow = (slow_cnt_next == '0);

endmodule

// ----- rtl/core/wheel_speed_rpm_odometer.sv -----
// top level of the wheel speed, engine rpm and odometer block
//
// input channel (in_valid / in_ready / in_data): one event per transaction,
// a millisecond tick, a wheel pulse falling edge or a button change
// output channel (out_valid / out_ready / out_data): exactly one result per
// input transaction, in order, with the latched rpm, speed, throttle, tyre
// diameter, odometer km and the per-event strobes
// config port (cfg_write / cfg_index / cfg_data): diameter limits, which the user
// must write only while the block is idle; the block itself does not enforce it
//
// items are handled one at a time; in_ready is high in the idle state
// ticks, buttons and ordinary pulses pass S_EXEC and then S_PUSH, which
// registers the result into the output register
// measuring pulse (every fifth pulse, the first being the sixth after reset):
// the shared bit-serial divider runs rpm, speed and throttle one after the
// other in S_DIV_RPM, S_DIV_SPD and S_DIV_THR, 19 quotient bits each
// the output register parts the two sides: a new item is accepted while the
// last result waits; when the receiver stalls the next result waits in the
// final state until the output register frees up
// reset clears time, counts, odometer and latched values, sets the diameter
// to 65 cm and the limits to 200 cm and 1 cm
module wheel_speed_rpm_odometer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  wsro_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output wsro_pkg::out_item_t              out_data,
    input  logic                             cfg_write,
    input  logic [wsro_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);
    import wsro_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_RPM,
        S_DIV_SPD,
        S_DIV_THR,
        S_PUSH
    } state_t;

    state_t         state_reg, state_next;
    in_item_t       item_reg, item_next;
    logic [15:0]    last_time_reg, last_time_next;
    logic [15:0]    dt_reg, dt_next;
    logic [2:0]     pulse_cnt_reg, pulse_cnt_next;
    logic [7:0]     diam_reg, diam_next;
    logic [ACCUM_W-1:0] accum_reg, accum_next;
    logic [15:0]    rpm_reg, rpm_next;
    logic [15:0]    speed_reg, speed_next;
    logic [7:0]     thr_reg, thr_next;
    logic           fast_reg, fast_next;
    logic           slow_reg, slow_next;
    logic           done_reg, done_next;
    logic [17:0]    spd_num_reg, spd_num_next;
    logic [17:0]    thr_num_reg, thr_num_next;
    logic [7:0]     diam_max_reg, diam_max_next;
    logic [7:0]     diam_min_reg, diam_min_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_data_reg, out_data_next;

    // time base and divider hookup
    logic               tb_advance;
    logic [31:0]        time_ms;
    tick_status_t       tick_strobes;
    logic               div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quot;
    div_status_t        div_status;

    // scratch
    logic [7:0]         diam_lo;
    logic [7:0]         diam_up;
    logic               push;
    logic               measure;

    wsro_timebase u_timebase (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (tb_advance),
        .time_ms (time_ms),
        .strobes (tick_strobes)
    );

    wsro_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .status (div_status)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign tb_advance = (state_reg == S_EXEC) && (item_reg.kind == KIND_TICK);
    assign measure    = (pulse_cnt_reg == PULSES_PER_MEASURE);
    assign push       = (state_reg == S_PUSH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        last_time_next = last_time_reg;
        dt_next        = dt_reg;
        pulse_cnt_next = pulse_cnt_reg;
        diam_next      = diam_reg;
        accum_next     = accum_reg;
        rpm_next       = rpm_reg;
        speed_next     = speed_reg;
        thr_next       = thr_reg;
        fast_next      = fast_reg;
        slow_next      = slow_reg;
        done_next      = done_reg;
        spd_num_next   = spd_num_reg;
        thr_num_next   = thr_num_reg;
        diam_max_next  = diam_max_reg;
        diam_min_next  = diam_min_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_num        = RPM_NUMERATOR;
        div_den        = dt_reg;
        diam_lo        = (diam_min_reg == '0) ? 8'd1 : diam_min_reg;
        diam_up        = diam_reg;

        // config writes land whenever they come
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DIAM_MAX: diam_max_next = cfg_data;
                CFG_DIAM_MIN: diam_min_next = cfg_data;
                default:      ;
            endcase
        end

        // output register empties when the receiver takes the transaction
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                fast_next  = 1'b0;
                slow_next  = 1'b0;
                done_next  = 1'b0;
                state_next = S_PUSH;
                case (item_reg.kind)
                    KIND_TICK:
                    begin
                        fast_next = tick_strobes.fast;
                        slow_next = tick_strobes.slow;
                    end
                    KIND_PULSE:
                    begin
                        accum_next = accum_reg + ACCUM_W'(ODO_INC_TABLE[diam_reg]);
                        if (measure)
                        begin
                            // elapsed time, kept to 16 bits
                            dt_next        = time_ms[15:0] - last_time_reg;
                            last_time_next = time_ms[15:0];
                            pulse_cnt_next = 3'd1;
                            spd_num_next   = 18'(diam_reg * SPEED_FACTOR);
                            thr_num_next   = {item_reg.adc_sample, 8'd0}
                                             - 18'(item_reg.adc_sample);
                            done_next      = 1'b1;
                            div_start      = 1'b1;
                            div_num        = RPM_NUMERATOR;
                            div_den        = time_ms[15:0] - last_time_reg;
                            state_next     = S_DIV_RPM;
                        end
                        else
                        begin
                            pulse_cnt_next = pulse_cnt_reg + 1'b1;
                        end
                    end
                    KIND_BUTTON:
                    begin
                        // plus first, then minus on the stepped value
                        if (item_reg.plus_pressed && diam_reg < diam_max_reg)
                            diam_up = diam_reg + 1'b1;
                        if (item_reg.minus_pressed && diam_up > diam_lo)
                            diam_next = diam_up - 1'b1;
                        else
                            diam_next = diam_up;
                    end
                    default:
                    begin
                        // unused kind only clears the tick strobes and the measure flag
                    end
                endcase
            end
            S_DIV_RPM:
            begin
                if (div_status.done)
                begin
                    rpm_next   = (div_quot[DIV_NUM_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(spd_num_reg);
                    div_den    = dt_reg;
                    state_next = S_DIV_SPD;
                end
            end
            S_DIV_SPD:
            begin
                if (div_status.done)
                begin
                    speed_next = (div_quot[DIV_NUM_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(thr_num_reg);
                    div_den    = THROTTLE_DIV;
                    state_next = S_DIV_THR;
                end
            end
            S_DIV_THR:
            begin
                if (div_status.done)
                begin
                    thr_next   = (div_quot[DIV_NUM_W-1:8] != '0) ? 8'hFF : div_quot[7:0];
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.rpm           = rpm_reg;
                    out_data_next.speed_kmh     = speed_reg;
                    out_data_next.throttle_duty = thr_reg;
                    out_data_next.diameter_cm   = diam_reg;
                    out_data_next.odometer_km   = accum_reg[ACCUM_W-1:32];
                    out_data_next.fast_strobe   = fast_reg;
                    out_data_next.slow_strobe   = slow_reg;
                    out_data_next.measure_done  = done_reg;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            last_time_reg <= '0;
            dt_reg        <= '0;
            pulse_cnt_reg <= '0;
            diam_reg      <= DIAM_RESET;
            accum_reg     <= '0;
            rpm_reg       <= '0;
            speed_reg     <= '0;
            thr_reg       <= '0;
            fast_reg      <= 1'b0;
            slow_reg      <= 1'b0;
            done_reg      <= 1'b0;
            spd_num_reg   <= '0;
            thr_num_reg   <= '0;
            diam_max_reg  <= DIAM_MAX_RESET;
            diam_min_reg  <= DIAM_MIN_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            last_time_reg <= last_time_next;
            dt_reg        <= dt_next;
            pulse_cnt_reg <= pulse_cnt_next;
            diam_reg      <= diam_next;
            accum_reg     <= accum_next;
            rpm_reg       <= rpm_next;
            speed_reg     <= speed_next;
            thr_reg       <= thr_next;
            fast_reg      <= fast_next;
            slow_reg      <= slow_next;
            done_reg      <= done_next;
            spd_num_reg   <= spd_num_next;
            thr_num_reg   <= thr_num_next;
            diam_max_reg  <= diam_max_next;
            diam_min_reg  <= diam_min_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the divider is always idle when a new transaction can come in
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_status.busy)
        else $error("divider busy while accepting a transaction");

    // the pulse counter never runs past the measuring count
    assert property (@(posedge clk) disable iff (!rst_n)
        pulse_cnt_reg <= PULSES_PER_MEASURE)
        else $error("pulse counter out of range");

    // a measuring result never carries tick strobes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.measure_done) |-> (!out_data.fast_strobe && !out_data.slow_strobe))
        else $error("measure and tick strobes in one result");

    // a result ready to push into a free output register appears next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && !out_valid_reg) |=> out_valid_reg)
        else $error("result not pushed into free output register");

endmodule
